// ----- hdl/jamd_pkg.sv -----
// Shared constants, types and helpers of the jet area median density block.
package jamd_pkg;

	localparam int MAX_JETS   = 256;
	localparam int BAND_COUNT = 5;
	localparam int AW         = $clog2(MAX_JETS);
	localparam int CW         = $clog2(MAX_JETS + 1);
	localparam int CFG_W      = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int REG_W      = 3;
	localparam int PASS_W     = 5;
	localparam int LAST_PASS  = 16;
	localparam int DIV_STEPS  = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXCLUDED = 3'd0,
		REG_ETA_MIN  = 3'd1,
		REG_ETA_MAX  = 3'd2,
		REG_RADIUS   = 3'd3,
		REG_INNER    = 3'd4,
		REG_MIDDLE   = 3'd5,
		REG_OUTER    = 3'd6
	} cfg_reg_t;

	// controller -> datapath
	typedef struct packed {
		logic              accept;
		logic              div_step;
		logic              store;
		logic              scan_clr;
		logic              scan_issue;
		logic              pass_fin;
		logic              emit;
		logic              ev_clr;
		logic [REG_W-1:0]  region;
		logic [PASS_W-1:0] pass;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_keep;
		logic in_last;
		logic last_q;
		logic scan_done;
	} sts_t;

	// Signed band edge from the list [-outer,-middle,-inner,inner,middle,outer];
	// indexes past the end clamp to +outer.
	function automatic logic signed [13:0] band_edge(input logic [REG_W-1:0] idx,
			input logic [10:0] inner, input logic [10:0] middle,
			input logic [10:0] outer);
		logic signed [13:0] e;
		unique case (idx)
			3'd0: e = -$signed({3'b000, outer});
			3'd1: e = -$signed({3'b000, middle});
			3'd2: e = -$signed({3'b000, inner});
			3'd3: e = $signed({3'b000, inner});
			3'd4: e = $signed({3'b000, middle});
			default: e = $signed({3'b000, outer});
		endcase
		return e;
	endfunction

endpackage

// ----- hdl/jamd_ram.sv -----
// Generic single write port RAM with registered read.
module jamd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/jamd_dp.sv -----
// Datapath: config registers, input filter, serial divider, stores, radix select.
module jamd_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [jamd_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [jamd_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                            jet_valid,
	input  logic [15:0]                     jet_pt,
	input  logic signed [11:0]              jet_eta,
	input  logic [11:0]                     jet_area,
	input  logic [15:0]                     mass_sum,
	input  logic                            last_jet,
	input  jamd_pkg::cmd_t                  cmd,
	output jamd_pkg::sts_t                  sts,
	output logic                            result_valid,
	output logic [jamd_pkg::REG_W-1:0]      region,
	output logic [15:0]                     rho,
	output logic [15:0]                     rho_mass,
	output logic [8:0]                      used_count,
	output logic                            last_result
);

	localparam int CW = jamd_pkg::CW;
	localparam int AW = jamd_pkg::AW;

	logic [3:0]         excl_q;
	logic signed [11:0] eta_min_q, eta_max_q;
	logic [9:0]         radius_q;
	logic [10:0]        inner_q, middle_q, outer_q;

	logic [3:0]         dropped_q;
	logic [CW-1:0]      kept_q;
	logic               last_q;
	logic [11:0]        area_q;
	logic signed [11:0] eta_q;

	logic [11:0] drem_q, mrem_q;
	logic [15:0] dsh_q, msh_q, dq_q, mq_q;
	logic        dsat_q, msat_q;

	logic [CW-1:0] addr_q;
	logic          rv_s1;
	logic [15:0]   dens_rd, mass_rd;
	logic [11:0]   eta_rd;

	logic [CW-1:0] n_acc_q, n_q;
	logic [15:0]   pref_q [4];
	logic [CW-1:0] k_q    [4];
	logic [CW-1:0] cnt_q  [4];

	logic pass_win, drop;
	logic [12:0] d_try, m_try, d_sub, m_sub;
	logic        d_ge, m_ge;
	logic signed [13:0] lo, hi, eta_x;
	logic        in_set;
	logic [3:0]  bitp;
	logic [15:0] hmask;
	logic [15:0] sel_val [4];
	logic [16:0] rho_sum, mass_sum2;

	// input filter
	assign pass_win = jet_valid && (jet_pt != 16'd0) && (jet_eta >= eta_min_q)
		&& (jet_eta <= eta_max_q);
	assign drop = dropped_q < excl_q;
	assign sts.in_keep = pass_win && !drop && (jet_area != 12'd0)
		&& (kept_q < CW'(jamd_pkg::MAX_JETS));
	assign sts.in_last = last_jet;
	assign sts.last_q = last_q;
	assign sts.scan_done = addr_q == kept_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			excl_q    <= 4'd2;
			eta_min_q <= -12'sd1280;
			eta_max_q <= 12'sd1280;
			radius_q  <= 10'd102;
			inner_q   <= 11'd538;
			middle_q  <= 11'd768;
			outer_q   <= 11'd1280;
		end else if (cfg_we) begin
			unique case (jamd_pkg::cfg_reg_t'(cfg_addr))
				jamd_pkg::REG_EXCLUDED: excl_q <= cfg_wdata[3:0];
				jamd_pkg::REG_ETA_MIN:  eta_min_q <= $signed(cfg_wdata);
				jamd_pkg::REG_ETA_MAX:  eta_max_q <= $signed(cfg_wdata);
				jamd_pkg::REG_RADIUS:   radius_q <= cfg_wdata[9:0];
				jamd_pkg::REG_INNER:    inner_q <= cfg_wdata[10:0];
				jamd_pkg::REG_MIDDLE:   middle_q <= cfg_wdata[10:0];
				jamd_pkg::REG_OUTER:    outer_q <= cfg_wdata[10:0];
				default: ;
			endcase
		end
	end

	// event counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dropped_q <= '0;
			kept_q    <= '0;
			last_q    <= 1'b0;
		end else begin
			if (cmd.accept) begin
				last_q <= last_jet;
				if (pass_win && drop) begin
					dropped_q <= dropped_q + 4'd1;
				end
			end
			if (cmd.store) begin
				kept_q <= kept_q + 1'b1;
			end
			if (cmd.ev_clr) begin
				dropped_q <= '0;
				kept_q    <= '0;
			end
		end
	end

	// restoring divider, one quotient bit a cycle; saturation known up front
	assign d_try = {drem_q, dsh_q[15]};
	assign m_try = {mrem_q, msh_q[15]};
	assign d_ge  = d_try >= {1'b0, area_q};
	assign m_ge  = m_try >= {1'b0, area_q};
	assign d_sub = d_try - {1'b0, area_q};
	assign m_sub = m_try - {1'b0, area_q};

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			area_q <= jet_area;
			eta_q  <= jet_eta;
			drem_q <= {2'b00, jet_pt[15:6]};
			mrem_q <= {2'b00, mass_sum[15:6]};
			dsh_q  <= {jet_pt[5:0], 10'd0};
			msh_q  <= {mass_sum[5:0], 10'd0};
			dsat_q <= {2'b00, jet_pt} >= {jet_area, 6'd0};
			msat_q <= {2'b00, mass_sum} >= {jet_area, 6'd0};
		end else if (cmd.div_step) begin
			drem_q <= d_ge ? d_sub[11:0] : d_try[11:0];
			mrem_q <= m_ge ? m_sub[11:0] : m_try[11:0];
			dsh_q  <= {dsh_q[14:0], 1'b0};
			msh_q  <= {msh_q[14:0], 1'b0};
			dq_q   <= {dq_q[14:0], d_ge};
			mq_q   <= {mq_q[14:0], m_ge};
		end
	end

	jamd_ram #(.WIDTH(16), .DEPTH(jamd_pkg::MAX_JETS)) u_dens (
		.clk(clk), .we(cmd.store), .waddr(kept_q[AW-1:0]),
		.wdata(dsat_q ? 16'hFFFF : dq_q), .raddr(addr_q[AW-1:0]), .rdata(dens_rd)
	);
	jamd_ram #(.WIDTH(16), .DEPTH(jamd_pkg::MAX_JETS)) u_mass (
		.clk(clk), .we(cmd.store), .waddr(kept_q[AW-1:0]),
		.wdata(msat_q ? 16'hFFFF : mq_q), .raddr(addr_q[AW-1:0]), .rdata(mass_rd)
	);
	jamd_ram #(.WIDTH(12), .DEPTH(jamd_pkg::MAX_JETS)) u_eta (
		.clk(clk), .we(cmd.store), .waddr(kept_q[AW-1:0]),
		.wdata(eta_q), .raddr(addr_q[AW-1:0]), .rdata(eta_rd)
	);

	// band membership
	assign lo = jamd_pkg::band_edge(cmd.region - 3'd1, inner_q, middle_q, outer_q)
		+ $signed({4'b0000, radius_q});
	assign hi = jamd_pkg::band_edge(cmd.region, inner_q, middle_q, outer_q)
		- $signed({4'b0000, radius_q});
	assign eta_x  = 14'($signed(eta_rd));
	assign in_set = (cmd.region == 3'd0) || ((eta_x >= lo) && (eta_x < hi));

	// radix select: pass p decides bit 16-p of each of four order statistics
	assign bitp  = 4'(5'd16 - cmd.pass);
	assign hmask = 16'hFFFF << ({1'b0, bitp} + 5'd1);
	assign sel_val[0] = dens_rd;
	assign sel_val[1] = dens_rd;
	assign sel_val[2] = mass_rd;
	assign sel_val[3] = mass_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			rv_s1  <= 1'b0;
		end else begin
			rv_s1 <= cmd.scan_issue;
			if (cmd.scan_clr) begin
				addr_q <= '0;
			end else if (cmd.scan_issue) begin
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_clr) begin
			n_acc_q <= '0;
			for (int s = 0; s < 4; s++) begin
				cnt_q[s] <= '0;
			end
		end else if (rv_s1 && in_set) begin
			if (cmd.pass == '0) begin
				n_acc_q <= n_acc_q + 1'b1;
			end else begin
				for (int s = 0; s < 4; s++) begin
					if ((((sel_val[s] ^ pref_q[s]) & hmask) == 16'd0)
							&& !sel_val[s][bitp]) begin
						cnt_q[s] <= cnt_q[s] + 1'b1;
					end
				end
			end
		end
		if (cmd.pass_fin) begin
			if (cmd.pass == '0) begin
				n_q <= n_acc_q;
				for (int s = 0; s < 4; s++) begin
					pref_q[s] <= '0;
					k_q[s] <= (s % 2 == 0) ? CW'((n_acc_q - 1'b1) >> 1) : CW'(n_acc_q >> 1);
				end
			end else begin
				for (int s = 0; s < 4; s++) begin
					if (k_q[s] >= cnt_q[s]) begin
						k_q[s] <= k_q[s] - cnt_q[s];
						pref_q[s][bitp] <= 1'b1;
					end
				end
			end
		end
	end

	// results
	assign rho_sum   = {1'b0, pref_q[0]} + {1'b0, pref_q[1]};
	assign mass_sum2 = {1'b0, pref_q[2]} + {1'b0, pref_q[3]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			region      <= cmd.region;
			rho         <= (n_q == '0) ? 16'd0 : rho_sum[16:1];
			rho_mass    <= (n_q == '0) ? 16'd0 : mass_sum2[16:1];
			used_count  <= 9'(n_q);
			last_result <= cmd.region == jamd_pkg::REG_W'(jamd_pkg::BAND_COUNT);
		end
	end

endmodule

// ----- hdl/jamd_ctrl.sv -----
// Controller: sequences loading, division, store scans and result emission.
module jamd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  jamd_pkg::sts_t sts,
	output jamd_pkg::cmd_t cmd,
	output logic           busy
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DIV   = 7'b0000010,
		ST_STORE = 7'b0000100,
		ST_SCAN  = 7'b0001000,
		ST_DRAIN = 7'b0010000,
		ST_FIN   = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [3:0] step_q, step_d;
	logic [jamd_pkg::PASS_W-1:0] pass_q, pass_d;
	logic [jamd_pkg::REG_W-1:0]  region_q, region_d;

	assign busy = state_q != ST_IDLE;

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		pass_d   = pass_q;
		region_d = region_q;
		cmd      = '0;
		cmd.region = region_q;
		cmd.pass   = pass_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					if (sts.in_keep) begin
						step_d  = '0;
						state_d = ST_DIV;
					end else if (sts.in_last) begin
						region_d = '0;
						pass_d = '0;
						cmd.scan_clr = 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				step_d = step_q + 4'd1;
				if (step_q == 4'(jamd_pkg::DIV_STEPS - 1)) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				if (sts.last_q) begin
					region_d = '0;
					pass_d = '0;
					cmd.scan_clr = 1'b1;
					state_d = ST_SCAN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_d = ST_DRAIN;
				end else begin
					cmd.scan_issue = 1'b1;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.pass_fin = 1'b1;
				if (pass_q == jamd_pkg::PASS_W'(jamd_pkg::LAST_PASS)) begin
					state_d = ST_EMIT;
				end else begin
					pass_d = pass_q + 1'b1;
					cmd.scan_clr = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (region_q == jamd_pkg::REG_W'(jamd_pkg::BAND_COUNT)) begin
					cmd.ev_clr = 1'b1;
					state_d = ST_IDLE;
				end else begin
					region_d = region_q + 1'b1;
					pass_d = '0;
					cmd.scan_clr = 1'b1;
					state_d = ST_SCAN;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			pass_q   <= '0;
			region_q <= '0;
		end else begin
			state_q  <= state_d;
			step_q   <= step_d;
			pass_q   <= pass_d;
			region_q <= region_d;
		end
	end

endmodule

// ----- hdl/jet_area_median_density.sv -----
// Top level of the jet area median density block.
// Usage:
//  - A request (one jet, or an event-closing item with jet_valid low) is taken
//    at a clock edge with start high and busy low.
//  - A jet that is kept is taken, run through the serial pt/area and mass/area
//    divider (one quotient bit a cycle), then stored. Skipped or dropped jets
//    do not raise busy.
//  - On the request marked last_jet the block emits six results, region 0
//    (all kept jets) then bands 1 to 5, each as a one-cycle result_valid
//    strobe. Each median is a 17-pass radix select over the stores (one count
//    pass, then one pass per value bit), each pass a full scan of the kept
//    jets, and the result is emitted after the last pass.
//  - busy stays high until the last result is out; the receiver cannot stall.
//  - Config writes (cfg_we, cfg_addr, cfg_wdata) land at once; issue them only
//    while the block is idle.
//  - Reset clears the controller, counters and config to defaults; the stores
//    are not cleared since only written entries are read.
module jet_area_median_density (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [jamd_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [jamd_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                           start,
	output logic                           busy,
	input  logic                           jet_valid,
	input  logic [15:0]                    jet_pt,
	input  logic signed [11:0]             jet_eta,
	input  logic [11:0]                    jet_area,
	input  logic [15:0]                    mass_sum,
	input  logic                           last_jet,
	output logic                           result_valid,
	output logic [jamd_pkg::REG_W-1:0]     region,
	output logic [15:0]                    rho,
	output logic [15:0]                    rho_mass,
	output logic [8:0]                     used_count,
	output logic                           last_result
);

	jamd_pkg::cmd_t cmd;
	jamd_pkg::sts_t sts;

	jamd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
	);

	jamd_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.jet_valid(jet_valid), .jet_pt(jet_pt), .jet_eta(jet_eta),
		.jet_area(jet_area), .mass_sum(mass_sum), .last_jet(last_jet),
		.cmd(cmd), .sts(sts),
		.result_valid(result_valid), .region(region), .rho(rho),
		.rho_mass(rho_mass), .used_count(used_count), .last_result(last_result)
	);

	// results other than the final band come out mid-event
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_result |-> busy)
		else $error("result before end of event without busy");

	// the final result is the highest band
	a_last_band: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_result |-> region == jamd_pkg::REG_W'(jamd_pkg::BAND_COUNT))
		else $error("last result on wrong region");

	// results are separated by at least one full scan
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("back to back result strobes");

endmodule
